@@ design/prvs_pkg.sv @@
// Package for the plate reading vote stabilizer.
// Holds payload structs, status codes and character helpers; no dependencies.
`timescale 1ns / 1ps
package prvs_pkg;
	typedef struct packed {
		logic [15:0] object_id;
		logic [47:0] now_ms;
		logic [3:0]  text_len;
		logic [63:0] chars_front;
		logic [63:0] chars_back;
	} req_in_t;

	typedef struct packed {
		logic [15:0] out_object;
		logic [1:0]  status;
		logic [3:0]  out_len;
		logic [63:0] out_front;
		logic [63:0] out_back;
		logic        was_restored;
	} req_out_t;

	typedef struct packed {
		logic [3:0]   len;
		logic [127:0] ch;
	} text_t;

	localparam logic [1:0] ST_EMIT = 2'd0;
	localparam logic [1:0] ST_HOLD = 2'd1;
	localparam logic [1:0] ST_REJ  = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_TTL    = 2'd1;
	localparam logic [1:0] REG_MIN    = 2'd2;

	function automatic logic is_dig(input logic [15:0] c);
		return (c >= 16'h0030) && (c <= 16'h0039);
	endfunction

	function automatic logic is_hang(input logic [15:0] c);
		return (c >= 16'hAC00) && (c <= 16'hD7A3);
	endfunction

	function automatic logic digit_only(input text_t t);
		logic ok;
		ok = (t.len == 4'd7) || (t.len == 4'd8);
		for (int i = 0; i < 8; i++)
			if (i < t.len && !is_dig(t.ch[16*i +: 16])) ok = 1'b0;
		return ok;
	endfunction

	function automatic logic plate_form(input text_t t);
		logic ok;
		logic [3:0] h;
		ok = (t.len == 4'd7) || (t.len == 4'd8);
		h = (t.len == 4'd7) ? 4'd2 : 4'd3;
		for (int i = 0; i < 8; i++)
			if (i < t.len) begin
				if (i == h) begin
					if (!is_hang(t.ch[16*i +: 16])) ok = 1'b0;
				end else if (!is_dig(t.ch[16*i +: 16])) begin
					ok = 1'b0;
				end
			end
		return ok;
	endfunction

	function automatic logic text_eq(input text_t a, input text_t b);
		return (a.len == b.len) && (a.len <= 4'd8) && (a.ch == b.ch);
	endfunction

	// restore digit-only d from template t; bit 0 of result says success
	function automatic logic [132:0] restore(input text_t d, input text_t t);
		logic [3:0] h;
		logic same;
		text_t r;
		logic ok;
		h = (t.len == 4'd7) ? 4'd2 : 4'd3;
		ok = 1'b0;
		r = d;
		if (plate_form(t)) begin
			same = (d.len + 4'd1 == t.len);
			for (int i = 0; i < 8; i++)
				if (i < d.len) begin
					if (i < h) begin
						if (d.ch[16*i +: 16] != t.ch[16*i +: 16]) same = 1'b0;
					end else if (i < 7) begin
						if (d.ch[16*i +: 16] != t.ch[16*(i+1) +: 16]) same = 1'b0;
					end
				end
			if (same) begin
				r = t;
				ok = 1'b1;
			end else if (d.len == t.len && h < d.len) begin
				ok = 1'b1;
				for (int i = 0; i < 8; i++)
					if (i < d.len && i != h && d.ch[16*i +: 16] != t.ch[16*i +: 16])
						ok = 1'b0;
				r.ch[16*h +: 16] = t.ch[16*h +: 16];
			end
		end
		return {r, ok};
	endfunction
endpackage

@@ design/prvs_ctrl.sv @@
// Sequencer and shared compare unit of the plate reading vote stabilizer.
// Depends on prvs_pkg.
`timescale 1ns / 1ps
module prvs_ctrl #(
	parameter int OBJECT_SLOTS = 16,
	parameter int WINDOW_DEPTH = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enable,
	input  logic [31:0]         ttl,
	input  logic [3:0]          min_cnt,
	input  logic                in_valid,
	output logic                in_ready,
	input  prvs_pkg::req_in_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output prvs_pkg::req_out_t  out_data
);
	import prvs_pkg::*;
	localparam int SW = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
	localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int EN = OBJECT_SLOTS * WINDOW_DEPTH;
	localparam int EW = (EN > 1) ? $clog2(EN) : 1;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001, S_SCAN = 9'b000000010, S_PICK = 9'b000000100,
		S_REST = 9'b000001000, S_LAST = 9'b000010000, S_STORE = 9'b000100000,
		S_VOTE = 9'b001000000, S_DEC = 9'b010000000, S_OUT = 9'b100000000
	} state_t;
	state_t state_q;

	logic [OBJECT_SLOTS-1:0] valid_q;
	logic [15:0] obj_q [OBJECT_SLOTS];
	logic [47:0] upd_q [OBJECT_SLOTS];
	logic [FW-1:0] fill_q [OBJECT_SLOTS];
	logic [WW-1:0] head_q [OBJECT_SLOTS];
	logic [OBJECT_SLOTS-1:0] lv_q;
	text_t last_q [OBJECT_SLOTS];
	text_t win_mem [EN];

	req_in_t in_q;
	text_t t_q, cand_q, e_q, rd_q;
	logic [SW:0] s_q;
	logic [SW-1:0] slot_q, free_q;
	logic hit_q, free_ok_q, rest_q;
	logic [FW-1:0] k_q, j_q;
	logic [FW-1:0] cnt_q, bcnt_q, blast_q, lastj_q;
	logic have_best_q, rd_pend_q, ld_q;
	text_t best_q;
	req_out_t res_q;
	logic ov_q;

	text_t t_in;
	always_comb begin
		t_in.len = in_data.text_len;
		t_in.ch = {in_data.chars_back, in_data.chars_front};
		if (in_data.text_len <= 4'd8)
			for (int i = 0; i < 8; i++)
				if (i >= in_data.text_len) t_in.ch[16*i +: 16] = 16'h0;
	end

	function automatic logic [EW-1:0] eaddr(input logic [SW-1:0] s, input logic [FW:0] off,
		input logic [WW-1:0] hd);
		logic [FW:0] p;
		p = off + {{(FW+1-WW){1'b0}}, hd};
		if (p >= (FW+1)'(WINDOW_DEPTH)) p = p - (FW+1)'(WINDOW_DEPTH);
		if (p >= (FW+1)'(WINDOW_DEPTH)) p = p - (FW+1)'(WINDOW_DEPTH);
		return EW'(32'(s) * WINDOW_DEPTH + 32'(p));
	endfunction

	logic [SW-1:0] si;
	logic [47:0] age;
	logic [132:0] rres;
	assign si = s_q[SW-1:0];
	assign age = in_q.now_ms - upd_q[si];
	assign rres = restore(t_q, (state_q == S_LAST) ? last_q[slot_q] : rd_q);

	assign in_ready = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_data = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_STORE) win_mem[eaddr(slot_q,
			(fill_q[slot_q] < FW'(WINDOW_DEPTH)) ? (FW+1)'(fill_q[slot_q]) : '0,
			head_q[slot_q])] <= cand_q;
		rd_q <= win_mem[eaddr(slot_q, (FW+1)'(k_q), head_q[slot_q])];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			ov_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						in_q <= in_data;
						t_q <= t_in;
						if (!enable) begin
							res_q <= '{in_data.object_id, ST_EMIT, t_in.len, t_in.ch[63:0],
								t_in.ch[127:64], 1'b0};
							ov_q <= 1'b1;
						end else begin
							res_q <= '{in_data.object_id, ST_EMIT, 4'd0, 64'd0, 64'd0, 1'b0};
							s_q <= '0;
							hit_q <= 1'b0;
							free_ok_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// expire, then search for a hit or the first free slot
					if (s_q == (SW+1)'(OBJECT_SLOTS)) begin
						state_q <= S_PICK;
					end else begin
						if (valid_q[si] && in_q.now_ms > upd_q[si] && age > {16'h0, ttl}) begin
							valid_q[si] <= 1'b0;
							if (!free_ok_q) begin
								free_ok_q <= 1'b1;
								free_q <= si;
							end
						end else if (valid_q[si]) begin
							if (!hit_q && obj_q[si] == in_q.object_id) begin
								hit_q <= 1'b1;
								slot_q <= si;
							end
						end else if (!free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= si;
						end
						s_q <= s_q + 1'b1;
					end
				end
				S_PICK: begin
					rest_q <= 1'b0;
					cand_q <= t_q;
					if (!hit_q && !free_ok_q) begin
						res_q.status <= ST_FULL;
						state_q <= S_OUT;
					end else begin
						if (!hit_q) begin
							slot_q <= free_q;
							valid_q[free_q] <= 1'b1;
							obj_q[free_q] <= in_q.object_id;
							fill_q[free_q] <= '0;
							head_q[free_q] <= '0;
							lv_q[free_q] <= 1'b0;
							k_q <= '0;
						end else begin
							k_q <= fill_q[slot_q] - 1'b1;
						end
						rd_pend_q <= 1'b1;
						state_q <= (digit_only(t_q) && hit_q && fill_q[slot_q] != '0)
							? S_REST : S_LAST;
					end
				end
				S_REST: begin
					// newest to oldest; each entry is read, then compared
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (rres[0]) begin
						cand_q <= rres[132:1];
						rest_q <= 1'b1;
						state_q <= S_STORE;
					end else if (k_q == '0) begin
						state_q <= S_LAST;
					end else begin
						k_q <= k_q - 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				S_LAST: begin
					upd_q[slot_q] <= in_q.now_ms;
					if (!rest_q && digit_only(t_q) && lv_q[slot_q] && rres[0]) begin
						cand_q <= rres[132:1];
						rest_q <= 1'b1;
						state_q <= S_STORE;
					end else if (!plate_form(cand_q) && !digit_only(cand_q)) begin
						res_q.status <= ST_REJ;
						state_q <= S_OUT;
					end else begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					upd_q[slot_q] <= in_q.now_ms;
					if (fill_q[slot_q] < FW'(WINDOW_DEPTH)) begin
						fill_q[slot_q] <= fill_q[slot_q] + 1'b1;
					end else if (head_q[slot_q] == WW'(WINDOW_DEPTH - 1)) begin
						head_q[slot_q] <= '0;
					end else begin
						head_q[slot_q] <= head_q[slot_q] + 1'b1;
					end
					k_q <= '0;
					j_q <= '0;
					cnt_q <= '0;
					have_best_q <= 1'b0;
					ld_q <= 1'b1;
					rd_pend_q <= 1'b1;
					state_q <= S_VOTE;
				end
				S_VOTE: begin
					// j picks the entry, k walks the window against it
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (ld_q) begin
						e_q <= rd_q;
						ld_q <= 1'b0;
						k_q <= '0;
						cnt_q <= '0;
						rd_pend_q <= 1'b1;
					end else begin
						if (text_eq(e_q, rd_q)) begin
							cnt_q <= cnt_q + 1'b1;
							lastj_q <= k_q;
						end
						if (k_q == fill_q[slot_q] - 1'b1) begin
							state_q <= S_DEC;
						end else begin
							k_q <= k_q + 1'b1;
							rd_pend_q <= 1'b1;
						end
					end
				end
				S_DEC: begin
					logic better;
					text_t win;
					logic [FW-1:0] bc;
					better = !have_best_q || cnt_q > bcnt_q ||
						(cnt_q == bcnt_q && lastj_q > blast_q);
					win = better ? e_q : best_q;
					bc = better ? cnt_q : bcnt_q;
					if (better) begin
						best_q <= e_q;
						bcnt_q <= cnt_q;
						blast_q <= lastj_q;
					end
					have_best_q <= 1'b1;
					if (j_q == fill_q[slot_q] - 1'b1) begin
						state_q <= S_OUT;
						if ((min_cnt <= 4'(WINDOW_DEPTH) && bc < FW'(min_cnt)) ||
							min_cnt > 4'(WINDOW_DEPTH) ||
							(lv_q[slot_q] && text_eq(last_q[slot_q], win))) begin
							res_q <= '{res_q.out_object, ST_HOLD, 4'd0, 64'd0, 64'd0, rest_q};
						end else begin
							res_q <= '{res_q.out_object, ST_EMIT, win.len, win.ch[63:0],
								win.ch[127:64], rest_q};
							last_q[slot_q] <= win;
							lv_q[slot_q] <= 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
						k_q <= j_q + 1'b1;
						ld_q <= 1'b1;
						rd_pend_q <= 1'b1;
						state_q <= S_VOTE;
					end
				end
				S_OUT: begin
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> (state_q == S_IDLE)) else $error("result outside idle");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> $stable(res_q)) else $error("result changed");
`endif
endmodule

@@ design/plate_reading_vote_stabilizer_core.sv @@
// Plate reading vote stabilizer: top level with config registers.
// With enable off, requests pass straight through. One request at a time; the next
// is taken once the result is accepted. Reset (arst_n, async low) clears all
// histories and loads enable 1, TTL 15000 ms, minimum count 2.
`timescale 1ns / 1ps
module plate_reading_vote_stabilizer_core #(
	parameter int OBJECT_SLOTS = 16,
	parameter int WINDOW_DEPTH = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  prvs_pkg::req_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output prvs_pkg::req_out_t out_data
);
	import prvs_pkg::*;
	logic enable_q;
	logic [31:0] ttl_q;
	logic [3:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			ttl_q <= 32'd15000;
			min_q <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_TTL: ttl_q <= cfg_data;
				REG_MIN: min_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	prvs_ctrl #(.OBJECT_SLOTS(OBJECT_SLOTS), .WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
		.clk, .arst_n, .enable(enable_q), .ttl(ttl_q), .min_cnt(min_q),
		.in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
	);
endmodule
